@@ rtl/dadsr_envelope_level_assert.svh @@
// assertion macros shared by the envelope level checker
`ifndef DADSR_ENVELOPE_LEVEL_ASSERT_SVH
`define DADSR_ENVELOPE_LEVEL_ASSERT_SVH

// property checked every clock, quiet while reset is held
`define DADSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked every clock, reset included
`define DADSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dadsr_pkg.sv @@
// shared widths, register indexes, segment codes and pipeline types
package dadsr_pkg;

    localparam int TIME_BITS  = 16;
    localparam int LEVEL_BITS = 16;
    localparam int NUM_BITS   = TIME_BITS + LEVEL_BITS;

    // quotient bits resolved in each divider stage
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = (LEVEL_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_DELAY   = 3'd0,
        REG_ATTACK  = 3'd1,
        REG_PEAK    = 3'd2,
        REG_DECAY   = 3'd3,
        REG_SUSTAIN = 3'd4,
        REG_RELEASE = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEG_DELAY    = 3'd0,
        SEG_ATTACK   = 3'd1,
        SEG_DECAY    = 3'd2,
        SEG_SUSTAIN  = 3'd3,
        SEG_RELEASE  = 3'd4,
        SEG_FINISHED = 3'd5
    } seg_t;

    localparam logic [TIME_BITS-1:0]  RST_DELAY   = TIME_BITS'(0);
    localparam logic [TIME_BITS-1:0]  RST_ATTACK  = TIME_BITS'(50);
    localparam logic [LEVEL_BITS-1:0] RST_PEAK    = LEVEL_BITS'(58982);
    localparam logic [TIME_BITS-1:0]  RST_DECAY   = TIME_BITS'(100);
    localparam logic [LEVEL_BITS-1:0] RST_SUSTAIN = LEVEL_BITS'(45875);
    localparam logic [TIME_BITS-1:0]  RST_RELEASE = TIME_BITS'(200);

    // data that rides alongside the division: final level = base +/- quotient
    typedef struct packed {
        logic [LEVEL_BITS-1:0] base;
        logic                  sub;
        seg_t                  seg;
    } side_t;

endpackage

@@ rtl/dadsr_div_pipe.sv @@
// pipelined restoring divider, a few quotient bits per stage
module dadsr_div_pipe
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [dadsr_pkg::NUM_BITS-1:0]      num,
    input  logic [dadsr_pkg::TIME_BITS-1:0]     den,
    input  dadsr_pkg::side_t                    side_in,
    output logic                                out_valid,
    output logic [dadsr_pkg::LEVEL_BITS-1:0]    quot,
    output dadsr_pkg::side_t                    side_out
);

    localparam int TB = dadsr_pkg::TIME_BITS;
    localparam int LB = dadsr_pkg::LEVEL_BITS;
    localparam int NB = dadsr_pkg::NUM_BITS;
    localparam int NS = dadsr_pkg::DIV_STAGES;
    localparam int BPS = dadsr_pkg::DIV_BITS_PER_STAGE;

    // numerator is below den * 2^LB, so the top part starts below den
    logic [TB-1:0]          rem_reg  [NS];
    logic [LB-1:0]          low_reg  [NS];
    logic [LB-1:0]          q_reg    [NS];
    logic [TB-1:0]          den_reg  [NS];
    dadsr_pkg::side_t       side_reg [NS];
    logic [NS-1:0]          valid_reg;

    logic [TB-1:0]          rem_next [NS];
    logic [LB-1:0]          low_next [NS];
    logic [LB-1:0]          q_next   [NS];

    // what each stage starts from: the operands, then the stage before
    logic [TB-1:0]          rem_in   [NS];
    logic [LB-1:0]          low_in   [NS];
    logic [LB-1:0]          q_in     [NS];
    logic [TB-1:0]          den_in   [NS];
    dadsr_pkg::side_t       side_pre [NS];
    logic [NS-1:0]          valid_in;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0)
        begin : g_head
            assign rem_in[s]   = num[NB-1:LB];
            assign low_in[s]   = num[LB-1:0];
            assign q_in[s]     = '0;
            assign den_in[s]   = den;
            assign side_pre[s] = side_in;
            assign valid_in[s] = in_valid;
        end
        else
        begin : g_tail
            assign rem_in[s]   = rem_reg[s-1];
            assign low_in[s]   = low_reg[s-1];
            assign q_in[s]     = q_reg[s-1];
            assign den_in[s]   = den_reg[s-1];
            assign side_pre[s] = side_reg[s-1];
            assign valid_in[s] = valid_reg[s-1];
        end

        always_comb
        begin
            logic [TB-1:0] r;
            logic [LB-1:0] lo;
            logic [LB-1:0] q;
            logic [TB-1:0] d;
            logic [TB:0]   trial;
            r     = rem_in[s];
            lo    = low_in[s];
            q     = q_in[s];
            d     = den_in[s];
            trial = '0;
            for (int k = 0; k < BPS; k++)
            begin
                // the last stage may carry fewer live bits
                if (s * BPS + k < LB)
                begin
                    trial = {r, lo[LB-1]};
                    lo    = lo << 1;
                    if (trial >= {1'b0, d})
                    begin
                        trial = trial - {1'b0, d};
                        q     = {q[LB-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[LB-2:0], 1'b0};
                    end
                    r = trial[TB-1:0];
                end
            end
            rem_next[s] = r;
            low_next[s] = lo;
            q_next[s]   = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= valid_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                q_reg[s]    <= q_next[s];
                den_reg[s]  <= den_in[s];
                side_reg[s] <= side_pre[s];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot      = q_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

@@ rtl/dadsr_envelope_level.sv @@
// envelope level top level: config registers, segment decode, multiply, divide, output
//
// Delay/attack/decay/sustain/release envelope evaluator. Each item carries the
// milliseconds since note-on (or since note-off when released) and returns the
// envelope level and segment code. There is no per-voice state, so many voices
// can be time-multiplexed through it. One item is accepted per clock unless the
// output is held; an item passes through stages 1 to 3, the DIV_STAGES divider
// stages, which resolve two quotient bits each, and the output register. When
// the output is held by a low out_ready the whole pipeline freezes in place,
// and in_ready drops with it. Registers sit on an APB-style port at byte
// address 4*index and must only be written while no items are in flight.
module dadsr_envelope_level
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // apb configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [dadsr_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [dadsr_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [dadsr_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                    pready,
    // input items
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [dadsr_pkg::TIME_BITS-1:0]         elapsed_ms,
    input  logic                                    released,
    // result items
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [dadsr_pkg::LEVEL_BITS-1:0]        level,
    output logic [2:0]                              segment
);

    localparam int TB = dadsr_pkg::TIME_BITS;
    localparam int LB = dadsr_pkg::LEVEL_BITS;
    localparam int NB = dadsr_pkg::NUM_BITS;
    localparam int DB = dadsr_pkg::APB_DATA_BITS;

    // ---------------- configuration registers ----------------
    logic [TB-1:0] delay_reg;
    logic [TB-1:0] attack_reg;
    logic [LB-1:0] peak_reg;
    logic [TB-1:0] decay_reg;
    logic [LB-1:0] sustain_reg;
    logic [TB-1:0] release_reg;

    logic                  cfg_wr;
    dadsr_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = dadsr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= dadsr_pkg::RST_DELAY;
            attack_reg  <= dadsr_pkg::RST_ATTACK;
            peak_reg    <= dadsr_pkg::RST_PEAK;
            decay_reg   <= dadsr_pkg::RST_DECAY;
            sustain_reg <= dadsr_pkg::RST_SUSTAIN;
            release_reg <= dadsr_pkg::RST_RELEASE;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                dadsr_pkg::REG_DELAY:   delay_reg   <= pwdata[TB-1:0];
                dadsr_pkg::REG_ATTACK:  attack_reg  <= pwdata[TB-1:0];
                dadsr_pkg::REG_PEAK:    peak_reg    <= pwdata[LB-1:0];
                dadsr_pkg::REG_DECAY:   decay_reg   <= pwdata[TB-1:0];
                dadsr_pkg::REG_SUSTAIN: sustain_reg <= pwdata[LB-1:0];
                dadsr_pkg::REG_RELEASE: release_reg <= pwdata[TB-1:0];
                default: ;  // addresses past the list are ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            dadsr_pkg::REG_DELAY:   prdata = DB'(delay_reg);
            dadsr_pkg::REG_ATTACK:  prdata = DB'(attack_reg);
            dadsr_pkg::REG_PEAK:    prdata = DB'(peak_reg);
            dadsr_pkg::REG_DECAY:   prdata = DB'(decay_reg);
            dadsr_pkg::REG_SUSTAIN: prdata = DB'(sustain_reg);
            dadsr_pkg::REG_RELEASE: prdata = DB'(release_reg);
            default:                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // every stage moves together; only a held result stops it
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: delay and release compares ----------------
    logic          s1_valid_reg;
    logic          s1_rel_reg;
    logic          s1_in_delay_reg;     // t < delay
    logic          s1_in_release_reg;   // t < release
    logic [TB-1:0] s1_u_reg;            // t - delay
    logic [TB-1:0] s1_rmt_reg;          // release - t

    logic [TB:0] s1_u_next;
    logic [TB:0] s1_rmt_next;

    assign s1_u_next   = {1'b0, elapsed_ms} - {1'b0, delay_reg};
    assign s1_rmt_next = {1'b0, release_reg} - {1'b0, elapsed_ms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rel_reg        <= released;
            s1_in_delay_reg   <= s1_u_next[TB];
            s1_in_release_reg <= !s1_rmt_next[TB] && (s1_rmt_next[TB-1:0] != '0);
            s1_u_reg          <= s1_u_next[TB-1:0];
            s1_rmt_reg        <= s1_rmt_next[TB-1:0];
        end
    end

    // ---------------- stage 2: segment decode and operand select ----------------
    logic [TB:0]   s2_v;
    logic          s2_in_attack;
    logic          s2_in_decay;
    logic          s2_rise;
    logic [LB-1:0] s2_a_next;
    logic [TB-1:0] s2_b_next;
    logic [TB-1:0] s2_d_next;
    dadsr_pkg::side_t s2_side_next;

    assign s2_v         = {1'b0, s1_u_reg} - {1'b0, attack_reg};
    assign s2_in_attack = s2_v[TB];
    // zero-length decay never matches since v < 0 is impossible
    assign s2_in_decay  = s2_v[TB-1:0] < decay_reg;
    assign s2_rise      = sustain_reg > peak_reg;

    always_comb
    begin
        // default: nothing to divide, quotient comes out zero
        s2_a_next         = '0;
        s2_b_next         = '0;
        s2_d_next         = TB'(1);
        s2_side_next.base = '0;
        s2_side_next.sub  = 1'b0;
        s2_side_next.seg  = dadsr_pkg::SEG_DELAY;
        if (s1_rel_reg)
        begin
            if (s1_in_release_reg)
            begin
                // sustain * (release - t) / release
                s2_a_next        = sustain_reg;
                s2_b_next        = s1_rmt_reg;
                s2_d_next        = release_reg;
                s2_side_next.seg = dadsr_pkg::SEG_RELEASE;
            end
            else
            begin
                s2_side_next.seg = dadsr_pkg::SEG_FINISHED;
            end
        end
        else if (s1_in_delay_reg)
        begin
            s2_side_next.seg = dadsr_pkg::SEG_DELAY;
        end
        else if (s2_in_attack)
        begin
            // peak * u / attack
            s2_a_next        = peak_reg;
            s2_b_next        = s1_u_reg;
            s2_d_next        = attack_reg;
            s2_side_next.seg = dadsr_pkg::SEG_ATTACK;
        end
        else if (s2_in_decay)
        begin
            // peak -/+ v * |peak - sustain| / decay
            s2_a_next         = s2_rise ? (sustain_reg - peak_reg) : (peak_reg - sustain_reg);
            s2_b_next         = s2_v[TB-1:0];
            s2_d_next         = decay_reg;
            s2_side_next.base = peak_reg;
            s2_side_next.sub  = !s2_rise;
            s2_side_next.seg  = dadsr_pkg::SEG_DECAY;
        end
        else
        begin
            s2_side_next.base = sustain_reg;
            s2_side_next.seg  = dadsr_pkg::SEG_SUSTAIN;
        end
    end

    logic             s2_valid_reg;
    logic [LB-1:0]    s2_a_reg;
    logic [TB-1:0]    s2_b_reg;
    logic [TB-1:0]    s2_d_reg;
    dadsr_pkg::side_t s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_next;
            s2_d_reg    <= s2_d_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // ---------------- stage 3: product ----------------
    logic             s3_valid_reg;
    logic [NB-1:0]    s3_prod_reg;
    logic [TB-1:0]    s3_d_reg;
    dadsr_pkg::side_t s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_prod_reg <= NB'(s2_a_reg) * NB'(s2_b_reg);
            s3_d_reg    <= s2_d_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // ---------------- divider ----------------
    logic             div_valid;
    logic [LB-1:0]    div_quot;
    dadsr_pkg::side_t div_side;

    dadsr_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .num       (s3_prod_reg),
        .den       (s3_d_reg),
        .side_in   (s3_side_reg),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    // ---------------- output register ----------------
    logic [LB-1:0] level_reg;
    logic [LB-1:0] level_next;
    logic [2:0]    segment_reg;

    // quotient never exceeds the span, so no wrap either way
    assign level_next = div_side.sub ? (div_side.base - div_quot) : (div_side.base + div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            level_reg   <= level_next;
            segment_reg <= div_side.seg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign segment   = segment_reg;

endmodule

@@ rtl/dadsr_envelope_level_chk.sv @@
// port-level checker for the envelope level block, with its bind
`include "dadsr_envelope_level_assert.svh"

module dadsr_envelope_level_chk
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    pready,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic [dadsr_pkg::LEVEL_BITS-1:0]        level,
    input  logic [2:0]                              segment
);

    logic                              out_stall;
    logic                              out_free;
    logic                              out_silent;
    logic [dadsr_pkg::LEVEL_BITS+3:0]  out_item;

    assign out_stall  = out_valid && !out_ready;
    assign out_free   = !out_valid || out_ready;
    assign out_silent = out_valid && (segment == dadsr_pkg::SEG_DELAY ||
                                      segment == dadsr_pkg::SEG_FINISHED);
    assign out_item   = {out_valid, level, segment};

    // a held result stays put
    `DADSR_ASSERT(a_out_hold, out_stall |=> $stable(out_item), "result changed while stalled")

    // the pipeline only backs up behind a waiting result
    `DADSR_ASSERT(a_ready_when_free, out_free |-> in_ready, "input stalled with output free")

    // segment code stays in its legal range
    `DADSR_ASSERT(a_seg_range, out_valid |-> segment <= dadsr_pkg::SEG_FINISHED, "bad segment code")

    // silent segments give a zero level
    `DADSR_ASSERT(a_silent_zero, out_silent |-> level == '0, "nonzero level in silent segment")

    // the register port never waits
    `DADSR_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind dadsr_envelope_level dadsr_envelope_level_chk u_chk (.*);

@@ sim/tb_top.sv @@
// testbench for the envelope level block: directed and random items checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS     = dadsr_pkg::TIME_BITS;
    localparam int LEVEL_BITS    = dadsr_pkg::LEVEL_BITS;
    localparam int APB_ADDR_BITS = dadsr_pkg::APB_ADDR_BITS;
    localparam int APB_DATA_BITS = dadsr_pkg::APB_DATA_BITS;

    // latency of one item through the block, plus margin for settling
    localparam int PIPE_CYCLES = 4 + dadsr_pkg::DIV_STAGES;
    localparam int SETTLE_CYCLES = PIPE_CYCLES + 4;

    // byte addresses past the last register, writes there must change nothing
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNUSED_LO = APB_ADDR_BITS'(24);
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNUSED_HI = APB_ADDR_BITS'(28);

    // envelope settings as the block should hold them
    typedef struct {
        logic [TIME_BITS-1:0]  delay_ms;
        logic [TIME_BITS-1:0]  attack_ms;
        logic [LEVEL_BITS-1:0] peak;
        logic [TIME_BITS-1:0]  decay_ms;
        logic [LEVEL_BITS-1:0] sustain;
        logic [TIME_BITS-1:0]  release_ms;
    } env_regs_t;

    // one envelope result
    typedef struct {
        logic [LEVEL_BITS-1:0] level;
        dadsr_pkg::seg_t       seg;
    } env_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [TIME_BITS-1:0]     elapsed_ms = '0;
    logic                     released = 1'b0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [LEVEL_BITS-1:0]    level;
    logic [2:0]               segment;

    env_regs_t  env_regs;
    env_point_t pending_points[$];
    int         mismatches = 0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;

    dadsr_envelope_level i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elapsed_ms (elapsed_ms),
        .released   (released),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .level      (level),
        .segment    (segment)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // envelope predictor: level and segment for one elapsed time
    function automatic env_point_t calc_envelope(input logic [TIME_BITS-1:0] t,
                                                 input logic rel);
        env_point_t       pt;
        longint unsigned  tt, dl, at, pk, dc, su, rl, u, v, lvl;
        tt = t;
        dl = env_regs.delay_ms;
        at = env_regs.attack_ms;
        pk = env_regs.peak;
        dc = env_regs.decay_ms;
        su = env_regs.sustain;
        rl = env_regs.release_ms;
        lvl = 0;
        if (rel)
        begin
            // release always ramps down from sustain, a zero release is finished at once
            if (tt < rl)
            begin
                lvl = (su * (rl - tt)) / rl;
                pt.seg = dadsr_pkg::SEG_RELEASE;
            end
            else
            begin
                pt.seg = dadsr_pkg::SEG_FINISHED;
            end
        end
        else if (tt < dl)
        begin
            pt.seg = dadsr_pkg::SEG_DELAY;
        end
        else
        begin
            u = tt - dl;
            // attack bound is attack_ms counted from the end of the delay
            if (u < at)
            begin
                lvl = (pk * u) / at;
                pt.seg = dadsr_pkg::SEG_ATTACK;
            end
            else
            begin
                v = u - at;
                if (v < dc)
                begin
                    // decay moves toward sustain, upward when sustain is above peak
                    if (su <= pk)
                        lvl = pk - (v * (pk - su)) / dc;
                    else
                        lvl = pk + (v * (su - pk)) / dc;
                    pt.seg = dadsr_pkg::SEG_DECAY;
                end
                else
                begin
                    lvl = su;
                    pt.seg = dadsr_pkg::SEG_SUSTAIN;
                end
            end
        end
        pt.level = lvl[LEVEL_BITS-1:0];
        return pt;
    endfunction

    // value a register should read back, zero extended
    function automatic logic [APB_DATA_BITS-1:0] reg_value(input dadsr_pkg::reg_idx_t idx);
        logic [APB_DATA_BITS-1:0] val;
        val = '0;
        case (idx)
            dadsr_pkg::REG_DELAY:   val[TIME_BITS-1:0] = env_regs.delay_ms;
            dadsr_pkg::REG_ATTACK:  val[TIME_BITS-1:0] = env_regs.attack_ms;
            dadsr_pkg::REG_PEAK:    val[LEVEL_BITS-1:0] = env_regs.peak;
            dadsr_pkg::REG_DECAY:   val[TIME_BITS-1:0] = env_regs.decay_ms;
            dadsr_pkg::REG_SUSTAIN: val[LEVEL_BITS-1:0] = env_regs.sustain;
            dadsr_pkg::REG_RELEASE: val[TIME_BITS-1:0] = env_regs.release_ms;
            default:                val = '0;
        endcase
        return val;
    endfunction

    // result side: random back-pressure, and each accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        env_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got level %0d segment %0d",
                         $time, level, segment);
            end
            else
            begin
                want = pending_points.pop_front();
                if (level !== want.level || segment !== want.seg)
                begin
                    mismatches++;
                    $display("%0t: result mismatch, expected level %0d segment %0d, %s",
                             $time, want.level, want.seg,
                             $sformatf("got level %0d segment %0d", level, segment));
                end
            end
        end
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // apb write: setup cycle, access cycle, then an idle cycle
    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // apb read of one register, data taken at the end of the access cycle
    task automatic check_reg(input dadsr_pkg::reg_idx_t idx);
        logic [APB_DATA_BITS-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== reg_value(idx))
        begin
            mismatches++;
            $display("%0t: register %s read mismatch, expected %0d, got %0d",
                     $time, idx.name(), reg_value(idx), got);
        end
        @(posedge clk);
    endtask

    // register write with junk in the upper data bits, which the block must drop
    task automatic set_reg(input dadsr_pkg::reg_idx_t idx, input logic [15:0] value);
        logic [31:0] junk;
        junk = $urandom;
        apb_write({idx, 2'b00}, {junk[31:16], value});
        case (idx)
            dadsr_pkg::REG_DELAY:   env_regs.delay_ms = value;
            dadsr_pkg::REG_ATTACK:  env_regs.attack_ms = value;
            dadsr_pkg::REG_PEAK:    env_regs.peak = value;
            dadsr_pkg::REG_DECAY:   env_regs.decay_ms = value;
            dadsr_pkg::REG_SUSTAIN: env_regs.sustain = value;
            dadsr_pkg::REG_RELEASE: env_regs.release_ms = value;
            default:                ;
        endcase
    endtask

    // stop sending and wait for every predicted result, then let the pipe settle
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // send one item with random idle cycles ahead of it, predict on acceptance
    task automatic send_sample(input logic [TIME_BITS-1:0] t, input logic rel);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_ms <= t;
        released   <= rel;
        do
            @(posedge clk);
        while (!in_ready);
        pending_points.push_back(calc_envelope(t, rel));
    endtask

    // full reprogram, only with nothing in flight
    task automatic program_all(input logic [15:0] dl, input logic [15:0] at,
                               input logic [15:0] pk, input logic [15:0] dc,
                               input logic [15:0] su, input logic [15:0] rl);
        drain_results(SETTLE_CYCLES);
        set_reg(dadsr_pkg::REG_DELAY, dl);
        set_reg(dadsr_pkg::REG_ATTACK, at);
        set_reg(dadsr_pkg::REG_PEAK, pk);
        set_reg(dadsr_pkg::REG_DECAY, dc);
        set_reg(dadsr_pkg::REG_SUSTAIN, su);
        set_reg(dadsr_pkg::REG_RELEASE, rl);
    endtask

    // durations: zero, max, short ramps and anything at all
    function automatic logic [15:0] pick_duration();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hffff;
            2, 3:    return 16'($urandom_range(300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // elapsed times biased toward the active segments and their boundaries
    function automatic logic [TIME_BITS-1:0] pick_elapsed(input logic rel);
        longint unsigned mark, span;
        if (rel)
        begin
            mark = env_regs.release_ms;
            span = mark;
        end
        else
        begin
            span = env_regs.delay_ms + env_regs.attack_ms + env_regs.decay_ms;
            case ($urandom_range(2))
                0:       mark = env_regs.delay_ms;
                1:       mark = env_regs.delay_ms + env_regs.attack_ms;
                default: mark = span;
            endcase
        end
        if ($urandom_range(3) == 0)
        begin
            // right on a boundary or one before it
            if (mark > 0 && $urandom_range(1) == 1)
                mark = mark - 1;
            if (mark > 65535)
                mark = 65535;
            return mark[TIME_BITS-1:0];
        end
        span = span + span / 4 + 2;
        if (span > 65535 || $urandom_range(3) == 0)
            return TIME_BITS'($urandom_range(65535));
        return TIME_BITS'($urandom_range(int'(span)));
    endfunction

    // envelope at reset settings, at and near the segment boundaries
    task automatic test_reset_values();
        send_sample(16'd0, 1'b0);
        send_sample(16'd49, 1'b0);
        send_sample(16'd50, 1'b0);
        send_sample(16'd150, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd199, 1'b1);
        send_sample(16'd200, 1'b1);
    endtask

    // reset values read back, every register written and read, unused addresses ignored
    task automatic test_register_access();
        drain_results(SETTLE_CYCLES);
        check_reg(dadsr_pkg::REG_DELAY);
        check_reg(dadsr_pkg::REG_ATTACK);
        check_reg(dadsr_pkg::REG_PEAK);
        check_reg(dadsr_pkg::REG_DECAY);
        check_reg(dadsr_pkg::REG_SUSTAIN);
        check_reg(dadsr_pkg::REG_RELEASE);
        set_reg(dadsr_pkg::REG_DELAY, 16'h1234);
        set_reg(dadsr_pkg::REG_ATTACK, 16'h0321);
        set_reg(dadsr_pkg::REG_PEAK, 16'hedcb);
        set_reg(dadsr_pkg::REG_DECAY, 16'h0456);
        set_reg(dadsr_pkg::REG_SUSTAIN, 16'h5a5a);
        set_reg(dadsr_pkg::REG_RELEASE, 16'ha5a5);
        apb_write(ADDR_UNUSED_LO, 32'hffff_ffff);
        apb_write(ADDR_UNUSED_HI, 32'h0000_0000);
        check_reg(dadsr_pkg::REG_DELAY);
        check_reg(dadsr_pkg::REG_ATTACK);
        check_reg(dadsr_pkg::REG_PEAK);
        check_reg(dadsr_pkg::REG_DECAY);
        check_reg(dadsr_pkg::REG_SUSTAIN);
        check_reg(dadsr_pkg::REG_RELEASE);
    endtask

    // zero-length delay, attack, decay and release segments get skipped
    task automatic test_zero_length_segments();
        program_all(16'd0, 16'd0, 16'd40000, 16'd10, 16'd20000, 16'd0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd0, 1'b1);
        program_all(16'd7, 16'd5, 16'd30000, 16'd0, 16'd12000, 16'd3);
        send_sample(16'd6, 1'b0);
        send_sample(16'd11, 1'b0);
        send_sample(16'd12, 1'b0);
    endtask

    // sustain above peak, so the decay ramp climbs
    task automatic test_rising_decay();
        program_all(16'd2, 16'd3, 16'd1000, 16'd100, 16'd60000, 16'd50);
        send_sample(16'd5, 1'b0);
        send_sample(16'd55, 1'b0);
        send_sample(16'd104, 1'b0);
        send_sample(16'd25, 1'b1);
    endtask

    // all registers at max, then all at zero
    task automatic test_extremes();
        program_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_sample(16'd0, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'd0, 1'b1);
        program_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b1);
    endtask

    // random items, new random settings every hundred, one full drain mid-set
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
        int   n;
        logic rel;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                program_all(pick_duration(), pick_duration(), pick_level(),
                            pick_duration(), pick_level(), pick_duration());
            else if (n % 100 == 50)
                drain_results(0);
            rel = 1'($urandom_range(1));
            send_sample(pick_elapsed(rel), rel);
        end
    endtask

    initial
    begin
        env_regs.delay_ms   = dadsr_pkg::RST_DELAY;
        env_regs.attack_ms  = dadsr_pkg::RST_ATTACK;
        env_regs.peak       = dadsr_pkg::RST_PEAK;
        env_regs.decay_ms   = dadsr_pkg::RST_DECAY;
        env_regs.sustain    = dadsr_pkg::RST_SUSTAIN;
        env_regs.release_ms = dadsr_pkg::RST_RELEASE;
        // sender light, receiver heavy for the first stretch
        snd_idle_pct = 22;
        rcv_idle_pct = 66;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_access();
        test_zero_length_segments();
        test_rising_decay();
        test_extremes();
        test_random_traffic(22, 66, 600);
        test_random_traffic(66, 22, 600);
        test_random_traffic(0, 0, 600);

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
